[hdl/l4pc_pkg.sv]
// ----------------------------------------------------------------------------
// l4pc_pkg: shared types and constants for the L4 pseudo header checksum core
// Mode codes, packet field offsets and the transaction payload types.
// ----------------------------------------------------------------------------
package l4pc_pkg;

    localparam logic [1:0] MODE_TCP4 = 2'd0;
    localparam logic [1:0] MODE_UDP4 = 2'd1;
    localparam logic [1:0] MODE_TCP6 = 2'd2;

    localparam logic [16:0] PROTO_TCP    = 17'h00006;
    localparam logic [16:0] PROTO_UDP    = 17'd17;
    localparam logic [5:0]  V4_MIN_HDR   = 6'd20;
    localparam logic [5:0]  V6_HDR       = 6'd40;
    localparam logic [15:0] V6_CS_OFFSET = 16'd56;
    localparam logic [15:0] UDP_CS_DELTA = 16'd6;
    localparam logic [15:0] TCP_CS_DELTA = 16'd16;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] checksum_offset;
        logic        short_packet;
    } out_item_t;

endpackage

[hdl/l4pc_if.sv]
// ----------------------------------------------------------------------------
// l4pc_if: valid/ready channels of the L4 pseudo header checksum core
// Packet byte channel and checksum result channel.
// ----------------------------------------------------------------------------
interface l4pc_byte_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output mode, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input last_byte,
                    output ready);
endinterface

interface l4pc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic [15:0] checksum_offset;
    logic        short_packet;

    modport source (output valid, output checksum, output checksum_offset,
                    output short_packet, input ready);
    modport sink   (input valid, input checksum, input checksum_offset,
                    input short_packet, output ready);
endinterface

[hdl/l4pc_in_stage.sv]
// ----------------------------------------------------------------------------
// l4pc_in_stage: input register
// Captures one packet byte transaction and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module l4pc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    l4pc_byte_if.sink          pkt,
    input  logic               take,
    output logic               item_valid,
    output l4pc_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    l4pc_pkg::in_item_t item_reg;
    logic               load;

    assign pkt.ready  = !valid_reg || take;
    assign load       = pkt.valid && pkt.ready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.mode      <= pkt.mode;
            item_reg.data_byte <= pkt.data_byte;
            item_reg.last_byte <= pkt.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/l4pc_sum_engine.sv]
// ----------------------------------------------------------------------------
// l4pc_sum_engine: per-packet checksum state and single-pass byte update
// Folds pseudo header and segment words into a ones-complement sum.
// ----------------------------------------------------------------------------
module l4pc_sum_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  l4pc_pkg::in_item_t  item,
    input  logic                out_free,
    output logic                take,
    output logic                res_load,
    output l4pc_pkg::out_item_t res
);

    logic [15:0] pos_reg,  pos_next;
    logic [16:0] sum_reg,  sum_next;
    logic [5:0]  hdr_reg,  hdr_next;
    logic [15:0] decl_reg, decl_next;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  mode_reg, mode_next;

    logic        first;
    logic [1:0]  mode_eff;
    logic [5:0]  hdr_eff;
    logic [5:0]  hdr_v4;
    logic [15:0] decl_eff;
    logic [16:0] sum_eff;
    logic        v6;
    logic        udp;
    logic [15:0] cs_off;
    logic        at_cs;
    logic [7:0]  v;
    logic [15:0] w;
    logic [15:0] q;
    logic [15:0] hdr16;
    logic        add_en;
    logic [15:0] add_val;
    logic [15:0] decl_upd;
    logic [16:0] v6_end;
    logic [17:0] raw_sum;
    logic [16:0] sum_upd;
    logic [16:0] fin_fold;
    logic [15:0] csum;
    logic [15:0] pos_inc;

    // hold while a final byte would overwrite an untaken result
    assign take     = item_valid && (!item.last_byte || out_free);
    assign res_load = take && item.last_byte;

    assign first    = (pos_reg == 16'd0);
    assign mode_eff = first ? ((item.mode inside {l4pc_pkg::MODE_TCP4, l4pc_pkg::MODE_UDP4,
                                                  l4pc_pkg::MODE_TCP6})
                               ? item.mode : l4pc_pkg::MODE_TCP4)
                            : mode_reg;
    assign v6       = (mode_eff == l4pc_pkg::MODE_TCP6);
    assign udp      = (mode_eff == l4pc_pkg::MODE_UDP4);
    assign hdr_v4   = ({item.data_byte[3:0], 2'b00} < l4pc_pkg::V4_MIN_HDR)
                      ? l4pc_pkg::V4_MIN_HDR : {item.data_byte[3:0], 2'b00};
    assign hdr_eff  = first ? (v6 ? l4pc_pkg::V6_HDR : hdr_v4) : hdr_reg;
    assign decl_eff = first ? l4pc_pkg::LEN_MAX : decl_reg;
    assign sum_eff  = first ? (udp ? l4pc_pkg::PROTO_UDP : l4pc_pkg::PROTO_TCP) : sum_reg;
    assign hdr16    = {10'd0, hdr_eff};

    assign cs_off = v6  ? l4pc_pkg::V6_CS_OFFSET
                  : udp ? hdr16 + l4pc_pkg::UDP_CS_DELTA
                        : hdr16 + l4pc_pkg::TCP_CS_DELTA;

    // checksum field counts as zero
    assign at_cs = (pos_reg == cs_off) || ({1'b0, pos_reg} == ({1'b0, cs_off} + 17'd1));
    assign v     = at_cs ? 8'd0 : item.data_byte;
    assign w     = {held_reg, v};
    assign q     = pos_reg - 16'd1;
    assign v6_end = 17'd40 + {1'b0, w};

    always_comb
    begin
        add_en   = 1'b0;
        add_val  = 16'd0;
        decl_upd = decl_eff;
        if (!pos_reg[0])
        begin
            // odd-length segment: pad the final byte
            if ((pos_reg >= hdr16) && (({1'b0, pos_reg} + 17'd1) == {1'b0, decl_eff}))
            begin
                add_en  = 1'b1;
                add_val = {v, 8'd0};
            end
        end
        else
        begin
            if (!v6 && (q >= 16'd12) && (pos_reg <= 16'd19))
            begin
                add_en  = 1'b1;
                add_val = w;
            end
            else if (v6 && (q >= 16'd8) && (pos_reg <= 16'd39))
            begin
                add_en  = 1'b1;
                add_val = w;
            end
            else if ((q >= hdr16) && (pos_reg < decl_eff))
            begin
                add_en  = 1'b1;
                add_val = w;
            end
            else if (!v6 && (pos_reg == 16'd3))
            begin
                if (w >= hdr16)
                begin
                    decl_upd = w;
                    add_en   = 1'b1;
                    add_val  = w - hdr16;
                end
                else
                begin
                    decl_upd = hdr16;
                end
            end
            else if (v6 && (pos_reg == 16'd5))
            begin
                decl_upd = v6_end[16] ? l4pc_pkg::LEN_MAX : v6_end[15:0];
                add_en   = 1'b1;
                add_val  = w;
            end
        end
    end

    assign raw_sum  = {1'b0, sum_eff} + {2'b00, add_val};
    assign sum_upd  = add_en ? ({1'b0, raw_sum[15:0]} + {15'd0, raw_sum[17:16]}) : sum_eff;
    assign pos_inc  = (pos_reg == l4pc_pkg::LEN_MAX) ? pos_reg : pos_reg + 16'd1;
    assign fin_fold = {1'b0, sum_upd[15:0]} + {16'd0, sum_upd[16]};
    assign csum     = ~fin_fold[15:0];

    assign res.checksum        = (udp && (csum == 16'd0)) ? 16'hFFFF : csum;
    assign res.checksum_offset = cs_off;
    assign res.short_packet    = (pos_inc < decl_upd);

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hdr_next  = hdr_reg;
        decl_next = decl_reg;
        held_next = held_reg;
        mode_next = mode_reg;
        if (take)
        begin
            if (item.last_byte)
            begin
                // drop all per-packet state after the result
                pos_next  = 16'd0;
                sum_next  = 17'd0;
                hdr_next  = 6'd0;
                decl_next = 16'd0;
                held_next = 8'd0;
                mode_next = l4pc_pkg::MODE_TCP4;
            end
            else
            begin
                pos_next  = pos_inc;
                sum_next  = sum_upd;
                hdr_next  = hdr_eff;
                decl_next = decl_upd;
                held_next = pos_reg[0] ? held_reg : v;
                mode_next = mode_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 16'd0;
            sum_reg  <= 17'd0;
            hdr_reg  <= 6'd0;
            decl_reg <= 16'd0;
            held_reg <= 8'd0;
            mode_reg <= l4pc_pkg::MODE_TCP4;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            hdr_reg  <= hdr_next;
            decl_reg <= decl_next;
            held_reg <= held_next;
            mode_reg <= mode_next;
        end
    end

endmodule

[hdl/l4pc_out_stage.sv]
// ----------------------------------------------------------------------------
// l4pc_out_stage: result register
// Holds one checksum result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module l4pc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  l4pc_pkg::out_item_t res,
    output logic                out_free,
    l4pc_result_if.source       rsl
);

    logic                valid_reg;
    logic                valid_next;
    l4pc_pkg::out_item_t res_reg;

    assign out_free   = !valid_reg || rsl.ready;
    assign valid_next = load || (valid_reg && !rsl.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign rsl.valid           = valid_reg;
    assign rsl.checksum        = res_reg.checksum;
    assign rsl.checksum_offset = res_reg.checksum_offset;
    assign rsl.short_packet    = res_reg.short_packet;

endmodule

[hdl/l4_pseudo_header_checksum_core.sv]
// ----------------------------------------------------------------------------
// l4_pseudo_header_checksum_core: TCP/UDP transport checksum generator
// Throughput: one packet byte per clock; the byte update is a single pass.
// A final byte waits in the input register while an untaken result is held.
// Result path: the last byte is captured in the input register, then its
// result is loaded into the result register and held there until taken.
// Reset: asynchronous, active low; clears all packet state and both stages.
// ----------------------------------------------------------------------------
module l4_pseudo_header_checksum_core (
    input  logic          clk,
    input  logic          rst_n,
    l4pc_byte_if.sink     pkt,
    l4pc_result_if.source rsl
);

    logic                item_valid;
    l4pc_pkg::in_item_t  item;
    logic                take;
    logic                out_free;
    logic                res_load;
    l4pc_pkg::out_item_t res;

    l4pc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    l4pc_sum_engine u_sum_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    l4pc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .out_free (out_free),
        .rsl      (rsl)
    );

endmodule

[dv/tb_l4_pseudo_header_checksum_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_l4_pseudo_header_checksum_core: self-checking bench for the checksum core
// Streams TCP/IPv4, UDP/IPv4 and TCP/IPv6 packets byte by byte, with random
// idle gaps on the byte channel and random stalls on the result channel. A
// scoreboard computes each expected checksum, field offset and short flag
// per accepted byte and compares every returned result in order.
// ----------------------------------------------------------------------------
module tb_l4_pseudo_header_checksum_core;

    typedef logic [7:0] octet_t;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         DRAIN_WAIT  = 20;
    localparam int         RANDOM_BYTES = 1200;

    class l4_checksum_scoreboard;
        bit [15:0]            byte_cnt;
        bit [16:0]            sum_acc;
        bit [5:0]             hdr_len;
        bit [15:0]            seg_end;
        bit [7:0]             hi_byte;
        bit [1:0]             pkt_mode;
        l4pc_pkg::out_item_t  expected_sums[$];
        int                   errors;

        function new();
            errors = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_cnt = '0;
            sum_acc  = '0;
            hdr_len  = '0;
            seg_end  = '0;
            hi_byte  = '0;
            pkt_mode = l4pc_pkg::MODE_TCP4;
        endfunction

        function int unsigned fold(int unsigned s);
            return (s & 32'h0000FFFF) + (s >> 16);
        endfunction

        function void add_word(int unsigned w);
            sum_acc = 17'(fold(32'(sum_acc) + (w & 32'h0000FFFF)));
        endfunction

        function int pending_count();
            return expected_sums.size();
        endfunction

        // Advance the packet state by one accepted byte.
        function void predict_byte(l4pc_pkg::in_item_t it);
            int unsigned          p, cs_off, v, w, h, s, c, v6_end;
            bit                   v6;
            l4pc_pkg::out_item_t  exp_item;
            p = 32'(byte_cnt);
            if (p == 0)
            begin
                pkt_mode = (it.mode inside {l4pc_pkg::MODE_TCP4, l4pc_pkg::MODE_UDP4,
                                            l4pc_pkg::MODE_TCP6}) ?
                           it.mode : l4pc_pkg::MODE_TCP4;
                if (pkt_mode == l4pc_pkg::MODE_TCP6)
                begin
                    hdr_len = l4pc_pkg::V6_HDR;
                end
                else
                begin
                    h = 4 * 32'(it.data_byte[3:0]);
                    hdr_len = (h < 32'(l4pc_pkg::V4_MIN_HDR)) ? l4pc_pkg::V4_MIN_HDR : 6'(h);
                end
                seg_end = l4pc_pkg::LEN_MAX;
                sum_acc = (pkt_mode == l4pc_pkg::MODE_UDP4) ? l4pc_pkg::PROTO_UDP
                                                            : l4pc_pkg::PROTO_TCP;
            end
            v6 = (pkt_mode == l4pc_pkg::MODE_TCP6);
            if (v6)
                cs_off = 32'(l4pc_pkg::V6_CS_OFFSET);
            else if (pkt_mode == l4pc_pkg::MODE_UDP4)
                cs_off = 32'(hdr_len) + 32'(l4pc_pkg::UDP_CS_DELTA);
            else
                cs_off = 32'(hdr_len) + 32'(l4pc_pkg::TCP_CS_DELTA);

            // the checksum field itself counts as zero
            v = (p == cs_off || p == cs_off + 1) ? 0 : 32'(it.data_byte);

            if (p % 2 == 0)
            begin
                hi_byte = v[7:0];
                if (p >= 32'(hdr_len) && p + 1 == 32'(seg_end))
                    add_word(v << 8);
            end
            else
            begin
                w = {16'd0, hi_byte, v[7:0]};
                if (!v6 && p - 1 >= 12 && p <= 19)
                    add_word(w);
                if (v6 && p - 1 >= 8 && p <= 39)
                    add_word(w);
                if (p - 1 >= 32'(hdr_len) && p < 32'(seg_end))
                    add_word(w);
                if (!v6 && p == 3)
                begin
                    if (w >= 32'(hdr_len))
                    begin
                        seg_end = w[15:0];
                        add_word(w - 32'(hdr_len));
                    end
                    else
                    begin
                        seg_end = {10'd0, hdr_len};
                    end
                end
                if (v6 && p == 5)
                begin
                    v6_end = 32'(l4pc_pkg::V6_HDR) + w;
                    seg_end = (v6_end > 32'(l4pc_pkg::LEN_MAX)) ? l4pc_pkg::LEN_MAX
                                                                : v6_end[15:0];
                    add_word(w);
                end
            end

            if (byte_cnt < l4pc_pkg::LEN_MAX)
                byte_cnt++;

            if (it.last_byte)
            begin
                s = fold(32'(sum_acc));
                c = (~s) & 32'h0000FFFF;
                if (pkt_mode == l4pc_pkg::MODE_UDP4 && c == 0)
                    c = 32'h0000FFFF;
                exp_item.checksum        = c[15:0];
                exp_item.checksum_offset = cs_off[15:0];
                exp_item.short_packet    = (byte_cnt < seg_end);
                expected_sums.push_back(exp_item);
                clear_packet();
            end
        endfunction

        function void check_result(l4pc_pkg::out_item_t got);
            l4pc_pkg::out_item_t want;
            if (expected_sums.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: cs %h off %0d short %b",
                             got.checksum, got.checksum_offset, got.short_packet);
                return;
            end
            want = expected_sums.pop_front();
            if (got.checksum !== want.checksum ||
                got.checksum_offset !== want.checksum_offset ||
                got.short_packet !== want.short_packet)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected cs %h off %0d short %b, ",
                              "got cs %h off %0d short %b"},
                             want.checksum, want.checksum_offset, want.short_packet,
                             got.checksum, got.checksum_offset, got.short_packet);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   stall_cycles = 0;

    l4pc_byte_if   pkt_ch();
    l4pc_result_if rsl_ch();

    l4_pseudo_header_checksum_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch.sink),
        .rsl   (rsl_ch.source)
    );

    l4_checksum_scoreboard board;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    function automatic void put_word(ref octet_t q[$], input int idx, input int unsigned w);
        q[idx]     = w[15:8];
        q[idx + 1] = w[7:0];
    endfunction

    function automatic void make_v4(ref octet_t q[$], input logic [3:0] ihl, input int seg_len);
        int hdr;
        hdr = (ihl < 5) ? 20 : 4 * ihl;
        q.delete();
        repeat (hdr + seg_len) q.push_back(8'($urandom_range(0, 255)));
        q[0] = {4'h4, ihl};
        put_word(q, 2, hdr + seg_len);
    endfunction

    function automatic void make_v6(ref octet_t q[$], input int seg_len);
        q.delete();
        repeat (40 + seg_len) q.push_back(8'($urandom_range(0, 255)));
        q[0] = {4'h6, q[0][3:0]};
        put_word(q, 4, seg_len);
    endfunction

    function automatic void extend_bytes(ref octet_t q[$], input int n);
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void cut_to(ref octet_t q[$], input int n);
        while (q.size() > n) void'(q.pop_back());
    endfunction

    // Rewrite the final segment word so that the folded sum becomes all ones.
    function automatic void tune_zero_sum(ref octet_t q[$], input logic [1:0] md);
        l4_checksum_scoreboard calc;
        l4pc_pkg::in_item_t    it;
        int                    n;
        logic [15:0]           c;
        calc = new();
        n = q.size();
        q[n - 2] = '0;
        q[n - 1] = '0;
        for (int i = 0; i < n; i++)
        begin
            it.mode      = md;
            it.data_byte = q[i];
            it.last_byte = (i == n - 1);
            calc.predict_byte(it);
        end
        c = calc.expected_sums[0].checksum;
        q[n - 2] = c[15:8];
        q[n - 1] = c[7:0];
    endfunction

    task automatic push_byte(l4pc_pkg::in_item_t it, bit full_rate);
        int gap;
        gap = full_rate ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pkt_ch.valid = 1'b0;
            repeat (gap)
            begin
                pkt_ch.mode      = 2'($urandom_range(0, 3));
                pkt_ch.data_byte = 8'($urandom_range(0, 255));
                pkt_ch.last_byte = 1'($urandom_range(0, 1));
                @(negedge clk);
            end
        end
        pkt_ch.valid     = 1'b1;
        pkt_ch.mode      = it.mode;
        pkt_ch.data_byte = it.data_byte;
        pkt_ch.last_byte = it.last_byte;
        @(posedge clk);
        while (!pkt_ch.ready) @(posedge clk);
        board.predict_byte(it);
    endtask

    task automatic send_packet(logic [1:0] md, octet_t q[$], bit full_rate);
        l4pc_pkg::in_item_t it;
        for (int i = 0; i < q.size(); i++)
        begin
            // mode matters only on the first byte; scramble it elsewhere
            it.mode      = (i == 0) ? md : 2'($urandom_range(0, 3));
            it.data_byte = q[i];
            it.last_byte = (i == q.size() - 1);
            push_byte(it, full_rate);
        end
    endtask

    // Result side: alternate stall stretches and ready stretches.
    initial
    begin
        int g, n;
        rsl_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            g = idle_gap();
            repeat (g)
            begin
                @(negedge clk);
                rsl_ch.ready = 1'b0;
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (n)
            begin
                @(negedge clk);
                rsl_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        l4pc_pkg::out_item_t got;
        if (rst_n === 1'b1 && rsl_ch.valid === 1'b1 && rsl_ch.ready === 1'b1)
        begin
            got = {rsl_ch.checksum, rsl_ch.checksum_offset, rsl_ch.short_packet};
            board.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1) ||
            (rsl_ch.valid === 1'b1 && rsl_ch.ready === 1'b1))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        octet_t      q[$];
        int          r, seg, hdr, bytes_sent;
        logic [3:0]  ihl;
        logic [1:0]  md;

        rst_n            = 1'b0;
        pkt_ch.valid     = 1'b0;
        pkt_ch.mode      = l4pc_pkg::MODE_TCP4;
        pkt_ch.data_byte = '0;
        pkt_ch.last_byte = 1'b0;
        board = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // minimal TCP/IPv4, widest IHL with an odd segment
        make_v4(q, 4'd5, 0);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b0);
        make_v4(q, 4'd15, 7);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b0);
        make_v4(q, 4'd5, 9);
        send_packet(l4pc_pkg::MODE_UDP4, q, 1'b1);
        make_v6(q, 20);
        send_packet(l4pc_pkg::MODE_TCP6, q, 1'b0);

        // zero IPv6 payload, followed by stray bytes
        make_v6(q, 0);
        extend_bytes(q, 3);
        send_packet(l4pc_pkg::MODE_TCP6, q, 1'b0);

        // unused mode code falls back to TCP/IPv4
        make_v4(q, 4'd6, 10);
        send_packet(MODE_SPARE, q, 1'b0);

        // IHL below the minimum header
        make_v4(q, 4'd2, 4);
        send_packet(l4pc_pkg::MODE_UDP4, q, 1'b0);

        // total length below the header length
        make_v4(q, 4'd5, 10);
        put_word(q, 2, 8);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b0);

        // trailing bytes past the declared end
        make_v4(q, 4'd5, 4);
        extend_bytes(q, 6);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b1);

        // short packets, including ones that end before the length field
        make_v4(q, 4'd5, 20);
        cut_to(q, 30);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b0);
        make_v4(q, 4'd5, 0);
        cut_to(q, 2);
        send_packet(l4pc_pkg::MODE_UDP4, q, 1'b0);
        make_v6(q, 8);
        cut_to(q, 1);
        send_packet(l4pc_pkg::MODE_TCP6, q, 1'b0);

        // folded sum of all ones: UDP sends all ones, TCP sends zero
        make_v4(q, 4'd5, 12);
        tune_zero_sum(q, l4pc_pkg::MODE_UDP4);
        send_packet(l4pc_pkg::MODE_UDP4, q, 1'b0);
        make_v4(q, 4'd5, 24);
        tune_zero_sum(q, l4pc_pkg::MODE_TCP4);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b0);

        // all-ones and all-zeros byte patterns
        q.delete();
        repeat (30) q.push_back(8'hFF);
        send_packet(l4pc_pkg::MODE_UDP4, q, 1'b0);
        q.delete();
        repeat (20) q.push_back(8'h00);
        send_packet(l4pc_pkg::MODE_TCP4, q, 1'b0);

        // largest IPv6 payload length: the segment end clamps
        make_v6(q, 20);
        put_word(q, 4, 32'h0000FFFF);
        send_packet(l4pc_pkg::MODE_TCP6, q, 1'b1);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            r   = $urandom_range(0, 99);
            md  = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
            seg = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
            ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
            hdr = (ihl < 5) ? 20 : 4 * ihl;
            if (md == l4pc_pkg::MODE_TCP6)
                make_v6(q, seg);
            else
                make_v4(q, ihl, seg);

            if (r < 65)
            begin
                // well-formed packet, keep as built
            end
            else if (r < 75)
            begin
                if (q.size() > 1)
                    cut_to(q, $urandom_range(1, q.size() - 1));
            end
            else if (r < 85)
            begin
                extend_bytes(q, $urandom_range(1, 8));
            end
            else if (r < 92)
            begin
                if (md == l4pc_pkg::MODE_TCP6)
                begin
                    put_word(q, 4, 0);
                    cut_to(q, 40);
                    extend_bytes(q, $urandom_range(0, 8));
                end
                else
                begin
                    put_word(q, 2, $urandom_range(0, hdr - 1));
                end
            end
            else
            begin
                q.delete();
                extend_bytes(q, $urandom_range(1, 48));
                md = 2'($urandom_range(0, 3));
            end
            send_packet(md, q, $urandom_range(0, 3) == 0);
            bytes_sent += q.size();
        end

        @(negedge clk);
        pkt_ch.valid = 1'b0;

        while (board.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.errors == 0 && board.pending_count() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/l4pc_pkg.sv
hdl/l4pc_if.sv
hdl/l4pc_in_stage.sv
hdl/l4pc_sum_engine.sv
hdl/l4pc_out_stage.sv
hdl/l4_pseudo_header_checksum_core.sv
dv/tb_l4_pseudo_header_checksum_core.sv
